// ===== src/acia_sp_pkg.sv =====
// ----------------------------------------------------------------------------
// ACIA serial port package
// Shared sizes, request and control codes, status bit positions and the
// item and interface types of the serial port block.
// ----------------------------------------------------------------------------
package acia_sp_pkg;

	// FIFO sizes
	localparam int TX_DEPTH = 16;
	localparam int RX_DEPTH = 16;
	localparam int TX_AW    = $clog2(TX_DEPTH);
	localparam int RX_AW    = $clog2(RX_DEPTH);
	localparam int TX_CW    = $clog2(TX_DEPTH + 1);
	localparam int RX_CW    = $clog2(RX_DEPTH + 1);

	// CTS threshold register
	localparam int            CTS_W         = 5;
	localparam logic [CTS_W-1:0] CTS_LEVEL_RST = 5'd12;

	// request types
	localparam logic [2:0] REQ_CTRL_WR = 3'd0;
	localparam logic [2:0] REQ_TX_WR   = 3'd1;
	localparam logic [2:0] REQ_RX_RD   = 3'd2;
	localparam logic [2:0] REQ_RX_PUSH = 3'd3;
	localparam logic [2:0] REQ_TX_POP  = 3'd4;
	localparam logic [2:0] REQ_HOST_CTS = 3'd5;

	// control byte fields
	localparam logic [1:0] DS_MASTER_RST = 2'b11;
	localparam logic [1:0] DS_QUEUE_LB   = 2'b10;
	localparam logic [1:0] TC_TX_IRQ     = 2'b01;
	localparam logic [1:0] TC_RTS_OFF    = 2'b10;
	localparam logic [1:0] TC_CLOSE_LB   = 2'b11;
	localparam int CTRL_RXIRQ_BIT = 7;

	// status bit positions
	localparam int ST_RDRF = 0;
	localparam int ST_TDRE = 1;
	localparam int ST_CTS  = 3;
	localparam int ST_IRQ  = 7;

	// receive holding register update select
	localparam logic [2:0] HOLD_KEEP   = 3'd0;
	localparam logic [2:0] HOLD_CLEAR  = 3'd1;
	localparam logic [2:0] HOLD_DIRECT = 3'd2;
	localparam logic [2:0] HOLD_RAM    = 3'd3;
	localparam logic [2:0] HOLD_FWD    = 3'd4;

	typedef struct packed {
		logic [2:0] req_type;
		logic [7:0] data_byte;
		logic       cts_flag;
	} in_item_t;

	typedef struct packed {
		logic [7:0] status_byte;
		logic [7:0] rx_data;
		logic       irq;
		logic [7:0] tx_byte;
		logic       tx_valid;
		logic       dropped;
	} out_item_t;

	typedef struct packed {
		logic             we;
		logic [TX_AW-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [TX_AW-1:0] raddr;
	} tx_ram_op_t;

	typedef struct packed {
		logic             we;
		logic [RX_AW-1:0] waddr;
		logic [7:0]       wdata;
		logic             re;
		logic [RX_AW-1:0] raddr;
	} rx_ram_op_t;

	// item in flight between the control stage and the output register
	typedef struct packed {
		logic [7:0] status_byte;
		logic       irq;
		logic       tx_valid;
		logic       dropped;
		logic [2:0] hold_sel;
		logic [7:0] hold_data;
	} s1_item_t;

endpackage

// ===== src/acia_sp_ram.sv =====
// ----------------------------------------------------------------------------
// ACIA serial port RAM
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module acia_sp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read, holds when idle
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/acia_sp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ACIA serial port control
// Holds counts, pointers, mode flags and the CTS threshold, decodes each
// item, issues FIFO RAM accesses and registers the item's flags for stage 2.
// ----------------------------------------------------------------------------
module acia_sp_ctrl (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  acia_sp_pkg::in_item_t   in_item,
	input  logic                    cfg_wr_en,
	input  logic [acia_sp_pkg::CTS_W-1:0] cfg_wr_data,
	input  logic                    s1_adv,
	output logic                    s1_valid,
	output acia_sp_pkg::s1_item_t   s1_item,
	output acia_sp_pkg::tx_ram_op_t tx_op,
	output acia_sp_pkg::rx_ram_op_t rx_op
);

	logic [acia_sp_pkg::TX_CW-1:0] tx_cnt_q, n_tx_cnt;
	logic [acia_sp_pkg::RX_CW-1:0] rx_cnt_q, n_rx_cnt;
	logic [acia_sp_pkg::TX_AW-1:0] tx_head_q, tx_tail_q, n_tx_head, n_tx_tail;
	logic [acia_sp_pkg::RX_AW-1:0] rx_head_q, rx_tail_q, n_rx_head, n_rx_tail;
	logic txirq_q, rxirq_q, rts_off_q, lb_close_q, lb_queue_q, host_cts_q, rbf_q;
	logic n_txirq, n_rxirq, n_rts_off, n_lb_close, n_lb_queue, n_host_cts, n_rbf;
	logic [acia_sp_pkg::CTS_W-1:0] cts_level_q;
	logic                  s1_valid_q;
	acia_sp_pkg::s1_item_t s1_q, n_s1;
	logic                  accept;
	logic [1:0]            ds, tc;
	logic                  tbe, cts_off;

	assign in_ready = !s1_valid_q || s1_adv;
	assign accept   = in_valid && in_ready;
	assign s1_valid = s1_valid_q;
	assign s1_item  = s1_q;
	assign ds       = in_item.data_byte[1:0];
	assign tc       = in_item.data_byte[6:5];

	// item decode and post-item refresh
	always_comb begin
		n_tx_cnt   = tx_cnt_q;
		n_rx_cnt   = rx_cnt_q;
		n_tx_head  = tx_head_q;
		n_tx_tail  = tx_tail_q;
		n_rx_head  = rx_head_q;
		n_rx_tail  = rx_tail_q;
		n_txirq    = txirq_q;
		n_rxirq    = rxirq_q;
		n_rts_off  = rts_off_q;
		n_lb_close = lb_close_q;
		n_lb_queue = lb_queue_q;
		n_host_cts = host_cts_q;
		n_rbf      = rbf_q;
		tx_op      = '0;
		rx_op      = '0;
		n_s1       = '0;
		n_s1.hold_sel = acia_sp_pkg::HOLD_KEEP;
		tbe        = 1'b0;
		cts_off    = 1'b0;

		if (accept) begin
			unique case (in_item.req_type)
				acia_sp_pkg::REQ_CTRL_WR: begin
					if (ds == acia_sp_pkg::DS_MASTER_RST) begin
						n_tx_cnt   = '0;
						n_rx_cnt   = '0;
						n_tx_head  = '0;
						n_tx_tail  = '0;
						n_rx_head  = '0;
						n_rx_tail  = '0;
						n_txirq    = 1'b0;
						n_rxirq    = 1'b0;
						n_rts_off  = 1'b0;
						n_lb_close = 1'b0;
						n_lb_queue = 1'b0;
						n_host_cts = 1'b0;
						n_rbf      = 1'b0;
						n_s1.hold_sel = acia_sp_pkg::HOLD_CLEAR;
					end else begin
						n_rts_off  = (tc == acia_sp_pkg::TC_RTS_OFF);
						n_lb_close = (tc == acia_sp_pkg::TC_CLOSE_LB);
						n_lb_queue = (tc != acia_sp_pkg::TC_CLOSE_LB) &&
							(ds == acia_sp_pkg::DS_QUEUE_LB);
						n_txirq    = (tc == acia_sp_pkg::TC_TX_IRQ);
						n_rxirq    = in_item.data_byte[acia_sp_pkg::CTRL_RXIRQ_BIT];
					end
				end
				acia_sp_pkg::REQ_TX_WR: begin
					if (lb_close_q) begin
						n_rbf          = 1'b1;
						n_s1.hold_sel  = acia_sp_pkg::HOLD_DIRECT;
						n_s1.hold_data = in_item.data_byte;
					end else if (lb_queue_q) begin
						if (rx_cnt_q < acia_sp_pkg::RX_CW'(acia_sp_pkg::RX_DEPTH)) begin
							rx_op.we    = 1'b1;
							rx_op.waddr = rx_tail_q;
							rx_op.wdata = in_item.data_byte;
							n_rx_tail   = (rx_tail_q ==
								acia_sp_pkg::RX_AW'(acia_sp_pkg::RX_DEPTH - 1)) ?
								'0 : rx_tail_q + 1'b1;
							n_rx_cnt    = rx_cnt_q + 1'b1;
						end else begin
							n_s1.dropped = 1'b1;
						end
					end else begin
						if (tx_cnt_q < acia_sp_pkg::TX_CW'(acia_sp_pkg::TX_DEPTH)) begin
							tx_op.we    = 1'b1;
							tx_op.waddr = tx_tail_q;
							tx_op.wdata = in_item.data_byte;
							n_tx_tail   = (tx_tail_q ==
								acia_sp_pkg::TX_AW'(acia_sp_pkg::TX_DEPTH - 1)) ?
								'0 : tx_tail_q + 1'b1;
							n_tx_cnt    = tx_cnt_q + 1'b1;
						end else begin
							n_s1.dropped = 1'b1;
						end
					end
				end
				acia_sp_pkg::REQ_RX_RD: begin
					n_rbf = 1'b0;
				end
				acia_sp_pkg::REQ_RX_PUSH: begin
					if (rx_cnt_q < acia_sp_pkg::RX_CW'(acia_sp_pkg::RX_DEPTH)) begin
						rx_op.we    = 1'b1;
						rx_op.waddr = rx_tail_q;
						rx_op.wdata = in_item.data_byte;
						n_rx_tail   = (rx_tail_q ==
							acia_sp_pkg::RX_AW'(acia_sp_pkg::RX_DEPTH - 1)) ?
							'0 : rx_tail_q + 1'b1;
						n_rx_cnt    = rx_cnt_q + 1'b1;
					end else begin
						n_s1.dropped = 1'b1;
					end
				end
				acia_sp_pkg::REQ_TX_POP: begin
					if (tx_cnt_q != '0) begin
						tx_op.re      = 1'b1;
						tx_op.raddr   = tx_head_q;
						n_tx_head     = (tx_head_q ==
							acia_sp_pkg::TX_AW'(acia_sp_pkg::TX_DEPTH - 1)) ?
							'0 : tx_head_q + 1'b1;
						n_tx_cnt      = tx_cnt_q - 1'b1;
						n_s1.tx_valid = 1'b1;
					end
				end
				acia_sp_pkg::REQ_HOST_CTS: begin
					n_host_cts = in_item.cts_flag;
				end
				default: begin
				end
			endcase

			// stage a receive byte into the holding register
			if (!n_rbf && n_rx_cnt != '0 && !n_rts_off) begin
				rx_op.re  = 1'b1;
				rx_op.raddr = n_rx_head;
				n_rx_head = (n_rx_head == acia_sp_pkg::RX_AW'(acia_sp_pkg::RX_DEPTH - 1)) ?
					'0 : n_rx_head + 1'b1;
				n_rx_cnt  = n_rx_cnt - 1'b1;
				n_rbf     = 1'b1;
				// byte written in this same item: forward it past the RAM
				if (rx_op.we && rx_op.waddr == rx_op.raddr) begin
					n_s1.hold_sel  = acia_sp_pkg::HOLD_FWD;
					n_s1.hold_data = rx_op.wdata;
				end else begin
					n_s1.hold_sel  = acia_sp_pkg::HOLD_RAM;
				end
			end

			// status refresh
			tbe     = n_tx_cnt < acia_sp_pkg::TX_CW'(acia_sp_pkg::TX_DEPTH);
			cts_off = (int'(n_tx_cnt) > int'(cts_level_q)) || n_host_cts;
			n_s1.irq = (n_rxirq && n_rbf) || (n_txirq && tbe && !cts_off);
			n_s1.status_byte[acia_sp_pkg::ST_RDRF] = n_rbf;
			n_s1.status_byte[acia_sp_pkg::ST_TDRE] = tbe && !cts_off;
			n_s1.status_byte[acia_sp_pkg::ST_CTS]  = cts_off;
			n_s1.status_byte[acia_sp_pkg::ST_IRQ]  = n_s1.irq;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tx_cnt_q   <= '0;
			rx_cnt_q   <= '0;
			tx_head_q  <= '0;
			tx_tail_q  <= '0;
			rx_head_q  <= '0;
			rx_tail_q  <= '0;
			txirq_q    <= 1'b0;
			rxirq_q    <= 1'b0;
			rts_off_q  <= 1'b0;
			lb_close_q <= 1'b0;
			lb_queue_q <= 1'b0;
			host_cts_q <= 1'b0;
			rbf_q      <= 1'b0;
		end else if (accept) begin
			tx_cnt_q   <= n_tx_cnt;
			rx_cnt_q   <= n_rx_cnt;
			tx_head_q  <= n_tx_head;
			tx_tail_q  <= n_tx_tail;
			rx_head_q  <= n_rx_head;
			rx_tail_q  <= n_rx_tail;
			txirq_q    <= n_txirq;
			rxirq_q    <= n_rxirq;
			rts_off_q  <= n_rts_off;
			lb_close_q <= n_lb_close;
			lb_queue_q <= n_lb_queue;
			host_cts_q <= n_host_cts;
			rbf_q      <= n_rbf;
		end
	end

	// CTS threshold register, survives master reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cts_level_q <= acia_sp_pkg::CTS_LEVEL_RST;
		end else if (cfg_wr_en) begin
			cts_level_q <= cfg_wr_data;
		end
	end

	// stage 1 valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			s1_q <= n_s1;
		end
	end

endmodule

// ===== src/acia_serial_port_unit.sv =====
// ----------------------------------------------------------------------------
// ACIA serial port unit
// An accepted item passes through the stage 1 register and then the output register, which raises out_valid.
// Throughput: one item per cycle; in_ready drops only while a result waits
// on out_ready. Each FIFO RAM sees at most one write and one read per item.
// Reset: arst_n clears counts, pointers, flags and holding register and sets
// the CTS threshold to 12; FIFO contents are undefined until written.
// ----------------------------------------------------------------------------
module acia_serial_port_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  acia_sp_pkg::in_item_t   in_item,
	output logic                    out_valid,
	input  logic                    out_ready,
	output acia_sp_pkg::out_item_t  out_item,
	input  logic                    cfg_wr_en,
	input  logic [acia_sp_pkg::CTS_W-1:0] cfg_wr_data
);

	acia_sp_pkg::tx_ram_op_t tx_op;
	acia_sp_pkg::rx_ram_op_t rx_op;
	acia_sp_pkg::s1_item_t   s1_item;
	acia_sp_pkg::out_item_t  out_q;
	logic                    s1_valid;
	logic                    s1_adv;
	logic                    out_free;
	logic                    out_valid_q;
	logic [7:0]              tx_rdata, rx_rdata;
	logic [7:0]              holding_q, n_holding;

	assign out_free  = !out_valid_q || out_ready;
	assign s1_adv    = s1_valid && out_free;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	acia_sp_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.in_item     (in_item),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.s1_adv      (s1_adv),
		.s1_valid    (s1_valid),
		.s1_item     (s1_item),
		.tx_op       (tx_op),
		.rx_op       (rx_op)
	);

	acia_sp_ram #(.WIDTH(8), .DEPTH(acia_sp_pkg::TX_DEPTH)) u_tx_ram (
		.clk   (clk),
		.we    (tx_op.we),
		.waddr (tx_op.waddr),
		.wdata (tx_op.wdata),
		.re    (tx_op.re),
		.raddr (tx_op.raddr),
		.rdata (tx_rdata)
	);

	acia_sp_ram #(.WIDTH(8), .DEPTH(acia_sp_pkg::RX_DEPTH)) u_rx_ram (
		.clk   (clk),
		.we    (rx_op.we),
		.waddr (rx_op.waddr),
		.wdata (rx_op.wdata),
		.re    (rx_op.re),
		.raddr (rx_op.raddr),
		.rdata (rx_rdata)
	);

	// receive holding register update
	always_comb begin
		case (s1_item.hold_sel) inside
			acia_sp_pkg::HOLD_CLEAR:                        n_holding = '0;
			acia_sp_pkg::HOLD_DIRECT, acia_sp_pkg::HOLD_FWD: n_holding = s1_item.hold_data;
			acia_sp_pkg::HOLD_RAM:                          n_holding = rx_rdata;
			default:                                        n_holding = holding_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holding_q <= '0;
		end else if (s1_adv) begin
			holding_q <= n_holding;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			out_q.status_byte <= s1_item.status_byte;
			out_q.rx_data     <= n_holding;
			out_q.irq         <= s1_item.irq;
			out_q.tx_byte     <= s1_item.tx_valid ? tx_rdata : 8'd0;
			out_q.tx_valid    <= s1_item.tx_valid;
			out_q.dropped     <= s1_item.dropped;
		end
	end

endmodule

// ===== src/acia_sp_checker.sv =====
// ----------------------------------------------------------------------------
// ACIA serial port checker
// Port-level assertions on the serial port unit, attached by bind.
// ----------------------------------------------------------------------------
module acia_sp_checker (
	input logic                    clk,
	input logic                    arst_n,
	input logic                    in_valid,
	input logic                    in_ready,
	input logic                    out_valid,
	input logic                    out_ready,
	input acia_sp_pkg::out_item_t  out_item
);

	// stalled result item holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("result item changed while stalled");

	// irq line agrees with status bit
	a_irq_status: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.irq == out_item.status_byte[acia_sp_pkg::ST_IRQ])
		else $error("irq and status irq bit differ");

	// TDRE and CTS-off never together, unused status bits zero
	a_status_bits: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_item.status_byte[acia_sp_pkg::ST_TDRE] &&
			out_item.status_byte[acia_sp_pkg::ST_CTS]) &&
			out_item.status_byte[6:4] == 3'd0 && out_item.status_byte[2] == 1'b0)
		else $error("inconsistent status byte");

	// no popped byte reads as zero
	a_tx_byte_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_item.tx_valid |-> out_item.tx_byte == 8'd0)
		else $error("tx_byte nonzero without tx_valid");

	// accepted item passes stage 1 into the output register when the output is not blocked
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 (out_ready || !out_valid) |=> out_valid)
		else $error("result item not delivered");

endmodule

bind acia_serial_port_unit acia_sp_checker u_chk (.*);
